// File: rtl/core/rate_monotonic_background_scheduler_assert.svh
// assertion macros for the scheduler checker
`ifndef RATE_MONOTONIC_BACKGROUND_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_BACKGROUND_SCHEDULER_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define RMBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmbs same-cycle check failed");

// next-cycle implication, checked through reset as well
`define RMBS_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rmbs next-cycle check failed");

`endif

// File: rtl/core/rmbs_pkg.sv
// types and constants of the rate monotonic background scheduler
package rmbs_pkg;

    localparam int TASKS_MAX = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COMPUTE_W = 8;
    localparam int PERIOD_W = 16;
    localparam int REMAIN_W = 16;
    localparam int UNITS_W = 8;
    localparam int WAIT_OUT_W = 16;
    localparam int TICK_OUT_W = 16;
    localparam int TDATA_OUT_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMPUTE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMPUTE3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD3 = 3'd7;

    // run kinds
    localparam logic [1:0] KIND_PERIODIC = 2'd0;
    localparam logic [1:0] KIND_APERIODIC = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;

    // periodic unit's verdict for the current tick
    typedef struct packed {
        logic                 found;
        logic [1:0]           task_idx;
        logic [TASKS_MAX-1:0] miss;
    } t_per_sel;

    typedef struct packed {
        logic [TICK_OUT_W-1:0] tick_now;
        logic                  ap_dropped;
        logic [TASKS_MAX-1:0]  miss_mask;
        logic [WAIT_OUT_W-1:0] ap_wait;
        logic [1:0]            run_task;
    } t_result_data;

    typedef struct packed {
        logic [1:0]   run_kind;
        t_result_data data;
    } t_result;

endpackage

// File: rtl/core/rmbs_periodic.sv
// periodic task registers, release counters and rate monotonic pick
module rmbs_periodic #(
    parameter int NUM_TASKS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rmbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rmbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_step,
    output rmbs_pkg::t_per_sel                o_sel
);
    import rmbs_pkg::*;

    logic [COMPUTE_W-1:0] r_compute [TASKS_MAX];
    logic [PERIOD_W-1:0]  r_period  [TASKS_MAX];
    logic [PERIOD_W-1:0]  r_phase   [NUM_TASKS];
    logic [REMAIN_W-1:0]  r_remain  [NUM_TASKS];
    logic [PERIOD_W-1:0]  n_phase   [NUM_TASKS];
    logic [REMAIN_W-1:0]  n_remain  [NUM_TASKS];
    logic [REMAIN_W-1:0]  rel_remain [NUM_TASKS];
    logic [PERIOD_W-1:0]  eff_period [NUM_TASKS];
    logic [TASKS_MAX-1:0] miss;
    logic                 found;
    logic [1:0]           best;
    logic [PERIOD_W-1:0]  best_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TASKS_MAX; t++) begin
                r_compute[t] <= '0;
                r_period[t]  <= PERIOD_W'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index inside {[REG_COMPUTE0:REG_COMPUTE3]}) begin
                r_compute[i_cfg_index[1:0]] <= i_cfg_data[COMPUTE_W-1:0];
            end else if (i_cfg_index inside {[REG_PERIOD0:REG_PERIOD3]}) begin
                r_period[i_cfg_index[1:0]] <= i_cfg_data[PERIOD_W-1:0];
            end
        end
    end

    // releases, miss flags, phase advance
    always_comb begin
        logic                release_now;
        logic [REMAIN_W:0]   sum;
        logic [PERIOD_W:0]   phase_inc;
        miss = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            eff_period[t] = (r_period[t] == '0) ? PERIOD_W'(1) : r_period[t];
            release_now = (r_phase[t] == '0) && (r_compute[t] != '0);
            miss[t] = release_now && (r_remain[t] != '0);
            sum = {1'b0, r_remain[t]} + (REMAIN_W+1)'(r_compute[t]);
            if (release_now) begin
                rel_remain[t] = sum[REMAIN_W] ? '1 : sum[REMAIN_W-1:0];
            end else begin
                rel_remain[t] = r_remain[t];
            end
            phase_inc = {1'b0, r_phase[t]} + (PERIOD_W+1)'(1);
            n_phase[t] = (phase_inc >= {1'b0, eff_period[t]}) ? '0
                                                               : phase_inc[PERIOD_W-1:0];
        end
    end

    // shortest period first, lower index wins ties
    always_comb begin
        found = 1'b0;
        best = '0;
        best_period = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (rel_remain[t] != '0 && (!found || eff_period[t] < best_period)) begin
                found = 1'b1;
                best = 2'(t);
                best_period = eff_period[t];
            end
        end
        for (int t = 0; t < NUM_TASKS; t++) begin
            n_remain[t] = rel_remain[t] - REMAIN_W'(found && best == 2'(t));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_phase[t]  <= '0;
                r_remain[t] <= '0;
            end
        end else if (i_step) begin
            for (int t = 0; t < NUM_TASKS; t++) begin
                r_phase[t]  <= n_phase[t];
                r_remain[t] <= n_remain[t];
            end
        end
    end

    assign o_sel.found    = found;
    assign o_sel.task_idx = best;
    assign o_sel.miss     = miss;

endmodule

// File: rtl/core/rate_monotonic_background_scheduler.sv
// rate monotonic scheduler top level with background aperiodic queue
//
//  channel   | direction | beat contents
//  s_axis    | in        | tuser: ap_arrive ; tdata: ap_units
//  m_axis    | out       | tuser: run_kind ; tdata: run_task, ap_wait, miss_mask,
//            |           |        ap_dropped, tick_now
//  cfg       | in        | index 0..3 compute_task0..3, 4..7 period_task0..3
//
// one tick per cycle while input is ready: a beat is decided in the cycle it is accepted and is
// registered into the output register, or into the skid entry while the output is stalled.
// a two-entry output (register plus skid) keeps input ready while one result waits.
// reset (synchronous, active low) clears tick, phases, pending work and queue
// pointers; the queue memory itself is not cleared and needs no clearing pass.
// cfg is always ready and takes effect on the next tick.
module rate_monotonic_background_scheduler #(
    parameter int NUM_TASKS      = 4,
    parameter int AP_QUEUE_DEPTH = 8,
    parameter int TICK_BITS      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] ap_units
    input  logic [0:0]                          i_s_axis_tuser,  // [0] ap_arrive
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [1:0] run_task, [17:2] ap_wait, [21:18] miss_mask, [22] ap_dropped,
    // [38:23] tick_now, [39] zero
    output logic [rmbs_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata,
    output logic [1:0]                          o_m_axis_tuser,  // [1:0] run_kind
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rmbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rmbs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rmbs_pkg::*;

    localparam int PTR_W  = $clog2(AP_QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(AP_QUEUE_DEPTH + 1);
    localparam int WIDE_W = (TICK_BITS > WAIT_OUT_W) ? TICK_BITS : WAIT_OUT_W;

    logic                 accept;
    logic [UNITS_W-1:0]   in_units;
    logic                 in_job;
    t_per_sel             per_sel;

    logic [TICK_BITS-1:0] r_tick;
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;
    logic [CNT_W-1:0]     r_count;
    logic [TICK_BITS-1:0] r_head_tick;
    logic [UNITS_W-1:0]   r_head_rem;
    logic [TICK_BITS-1:0] mem_tick  [AP_QUEUE_DEPTH];
    logic [UNITS_W-1:0]   mem_units [AP_QUEUE_DEPTH];

    logic                 q_full;
    logic                 push;
    logic                 dropped;
    logic [CNT_W-1:0]     cnt_push;
    logic                 hv_byp;
    logic [TICK_BITS-1:0] hv_tick;
    logic [UNITS_W-1:0]   hv_rem;
    logic [UNITS_W-1:0]   rem_dec;
    logic                 ap_sel;
    logic                 serve;
    logic                 pop;
    logic                 next_from_input;
    logic [PTR_W-1:0]     head_nxt;
    logic [PTR_W-1:0]     tail_nxt;
    logic [TICK_BITS-1:0] diff;
    logic [WIDE_W-1:0]    diff_wide;
    logic [WIDE_W-1:0]    tick_wide;
    t_result              result;

    logic                 r_out_valid;
    t_result              r_out;
    logic                 r_skid_valid;
    t_result              r_skid;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_skid_valid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_units        = i_s_axis_tdata;
    assign in_job          = i_s_axis_tuser[0] && (in_units != '0);

    rmbs_periodic #(
        .NUM_TASKS (NUM_TASKS)
    ) u_periodic (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (accept),
        .o_sel       (per_sel)
    );

    // queue bookkeeping; head entry lives in r_head_tick/r_head_rem
    assign q_full   = (r_count == CNT_W'(AP_QUEUE_DEPTH));
    assign push     = accept && in_job && !q_full;
    assign dropped  = in_job && q_full;
    assign cnt_push = r_count + CNT_W'(in_job && !q_full);
    assign hv_byp   = (r_count == '0);
    assign hv_tick  = hv_byp ? r_tick : r_head_tick;
    assign hv_rem   = hv_byp ? in_units : r_head_rem;
    assign rem_dec  = hv_rem - UNITS_W'(1);
    assign ap_sel   = !per_sel.found && (cnt_push != '0);
    assign serve    = accept && ap_sel;
    assign pop      = serve && (rem_dec == '0);
    // next head is the job written this very tick
    assign next_from_input = in_job && (r_count == CNT_W'(1));
    assign head_nxt = (r_head == PTR_W'(AP_QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign tail_nxt = (r_tail == PTR_W'(AP_QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem_tick[r_tail]  <= r_tick;
            mem_units[r_tail] <= in_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (pop) begin
                if (next_from_input) begin
                    r_head_tick <= r_tick;
                    r_head_rem  <= in_units;
                end else begin
                    r_head_tick <= mem_tick[head_nxt];
                    r_head_rem  <= mem_units[head_nxt];
                end
            end else begin
                r_head_tick <= hv_tick;
                r_head_rem  <= serve ? rem_dec : hv_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_tick  <= r_tick + TICK_BITS'(1);
            r_count <= cnt_push - CNT_W'(pop);
            if (push) begin
                r_tail <= tail_nxt;
            end
            if (pop) begin
                r_head <= head_nxt;
            end
        end
    end

    assign diff      = r_tick - hv_tick;
    assign diff_wide = WIDE_W'(diff);
    assign tick_wide = WIDE_W'(r_tick);

    always_comb begin
        result = '0;
        result.data.tick_now   = tick_wide[TICK_OUT_W-1:0];
        result.data.ap_dropped = dropped;
        result.data.miss_mask  = per_sel.miss;
        if (per_sel.found) begin
            result.run_kind      = KIND_PERIODIC;
            result.data.run_task = per_sel.task_idx;
        end else if (ap_sel) begin
            result.run_kind     = KIND_APERIODIC;
            result.data.ap_wait = (diff_wide > WIDE_W'({WAIT_OUT_W{1'b1}}))
                                  ? '1 : diff_wide[WAIT_OUT_W-1:0];
        end else begin
            result.run_kind = KIND_IDLE;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.run_kind;
    assign o_m_axis_tdata  = TDATA_OUT_W'(r_out.data);

endmodule

// File: rtl/core/rmbs_checker.sv
// port-level checks for the scheduler, bound to the top level
`include "rate_monotonic_background_scheduler_assert.svh"

module rmbs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [rmbs_pkg::TDATA_OUT_W-1:0] o_m_axis_tdata,
    input logic [1:0]                       o_m_axis_tuser
);
    import rmbs_pkg::*;

    logic                   not_periodic;
    logic                   not_aperiodic;
    logic                   stalled;
    logic [1:0]             out_task;
    logic [WAIT_OUT_W-1:0]  out_wait;
    logic [TDATA_OUT_W+1:0] out_beat;

    assign not_periodic  = o_m_axis_tvalid && (o_m_axis_tuser != KIND_PERIODIC);
    assign not_aperiodic = o_m_axis_tvalid && (o_m_axis_tuser != KIND_APERIODIC);
    assign stalled       = i_rst_n && o_m_axis_tvalid && !i_m_axis_tready;
    assign out_task      = o_m_axis_tdata[1:0];
    assign out_wait      = o_m_axis_tdata[17:2];
    // whole beat, kind on top
    assign out_beat      = {o_m_axis_tuser, o_m_axis_tdata};

    `RMBS_ASSERT_SAME(a_kind_legal, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser <= KIND_IDLE)
    `RMBS_ASSERT_SAME(a_task_only_periodic, i_clk, i_rst_n, not_periodic, out_task == '0)
    `RMBS_ASSERT_SAME(a_wait_only_aperiodic, i_clk, i_rst_n, not_aperiodic, out_wait == '0)
    `RMBS_ASSERT_NEXT(a_stall_hold, i_clk, stalled, o_m_axis_tvalid && $stable(out_beat))
    `RMBS_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_m_axis_tvalid)

endmodule

bind rate_monotonic_background_scheduler rmbs_checker u_rmbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// File: tb/tb_rate_monotonic_background_scheduler.sv
// self-checking testbench for the rate monotonic scheduler with background aperiodic queue
module tb_rate_monotonic_background_scheduler;
    import rmbs_pkg::*;

    localparam int NTASK       = 4;
    localparam int QDEPTH      = 8;
    localparam int QUIET_LIMIT = 2000;

    logic                    i_clk;
    logic                    i_rst_n         = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [7:0]              i_s_axis_tdata  = '0;   // [7:0] ap_units
    logic [0:0]              i_s_axis_tuser  = '0;   // [0] ap_arrive
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // [1:0] run_task, [17:2] ap_wait, [21:18] miss_mask, [22] ap_dropped, [38:23] tick_now
    logic [TDATA_OUT_W-1:0]  o_m_axis_tdata;
    logic [1:0]              o_m_axis_tuser;         // [1:0] run_kind
    logic                    i_cfg_valid     = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data      = '0;

    rate_monotonic_background_scheduler #(
        .NUM_TASKS      (NTASK),
        .AP_QUEUE_DEPTH (QDEPTH),
        .TICK_BITS      (16)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // scheduler state as predicted
    logic [7:0]  task_compute [NTASK];
    logic [15:0] task_period  [NTASK];
    logic [15:0] task_phase   [NTASK];
    logic [15:0] task_pending [NTASK];
    logic [15:0] job_arrival  [QDEPTH];
    logic [7:0]  job_left     [QDEPTH];
    int          job_head;
    int          job_tail;
    int          job_count;
    logic [15:0] tick_ctr;

    // register values for the next programming pass
    logic [7:0]  next_compute [NTASK];
    logic [15:0] next_period  [NTASK];

    t_result     expected_ticks [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          src_idle_pct   = 25;
    int          sink_idle_pct  = 46;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic int unsigned eff_period(input int k);
        return (task_period[k] == 0) ? 1 : int'(task_period[k]);
    endfunction

    function automatic bit work_left();
        int k;
        work_left = (job_count != 0);
        for (k = 0; k < NTASK; k++) begin
            if (task_pending[k] != 0) work_left = 1'b1;
        end
    endfunction

    // one scheduler tick: releases, arrival, pick one unit, advance
    function automatic t_result sched_tick(input logic arrive, input logic [7:0] units);
        t_result     res;
        int unsigned sum;
        int          k;
        int          best;
        bit          found;
        res = '0;
        res.run_kind = KIND_IDLE;
        res.data.tick_now = tick_ctr;
        found = 1'b0;
        best = 0;
        for (k = 0; k < NTASK; k++) begin
            if (task_phase[k] == 0 && task_compute[k] != 0) begin
                if (task_pending[k] != 0) res.data.miss_mask[k] = 1'b1;
                sum = task_pending[k] + task_compute[k];
                task_pending[k] = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
            end
            // a phase left past a shortened period wraps right away
            if (int'(task_phase[k]) + 1 >= eff_period(k)) begin
                task_phase[k] = '0;
            end else begin
                task_phase[k] = task_phase[k] + 1'b1;
            end
        end
        if (arrive && units != 0) begin
            if (job_count >= QDEPTH) begin
                res.data.ap_dropped = 1'b1;
            end else begin
                job_arrival[job_tail] = tick_ctr;
                job_left[job_tail] = units;
                job_tail = (job_tail + 1) % QDEPTH;
                job_count++;
            end
        end
        for (k = 0; k < NTASK; k++) begin
            if (task_pending[k] != 0 && (!found || eff_period(k) < eff_period(best))) begin
                best = k;
                found = 1'b1;
            end
        end
        if (found) begin
            task_pending[best] = task_pending[best] - 1'b1;
            res.run_kind = KIND_PERIODIC;
            res.data.run_task = best[1:0];
        end else if (job_count != 0) begin
            res.run_kind = KIND_APERIODIC;
            // 16-bit difference gives the wait modulo the tick width
            res.data.ap_wait = tick_ctr - job_arrival[job_head];
            job_left[job_head] = job_left[job_head] - 1'b1;
            if (job_left[job_head] == 0) begin
                job_head = (job_head + 1) % QDEPTH;
                job_count--;
            end
        end
        tick_ctr = tick_ctr + 1'b1;
        return res;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result      want;
        t_result_data got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_result_data)-1:0];
            if (expected_ticks.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual tuser %0d tdata %h",
                         $time, o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                want = expected_ticks.pop_front();
                check_field("run_kind", 32'(want.run_kind), 32'(o_m_axis_tuser));
                check_field("run_task", 32'(want.data.run_task), 32'(got.run_task));
                check_field("ap_wait", 32'(want.data.ap_wait), 32'(got.ap_wait));
                check_field("miss_mask", 32'(want.data.miss_mask), 32'(got.miss_mask));
                check_field("ap_dropped", 32'(want.data.ap_dropped), 32'(got.ap_dropped));
                check_field("tick_now", 32'(want.data.tick_now), 32'(got.tick_now));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge; leaves tvalid high for a back-to-back beat
    task automatic send_tick(input logic arrive, input logic [7:0] units);
        t_result predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= units;
        i_s_axis_tuser  <= arrive;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = sched_tick(arrive, units);
        expected_ticks = {expected_ticks, predicted};
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_ticks.size() != 0) @(negedge i_clk);
    endtask

    // writes all eight registers from next_compute / next_period
    task automatic program_tasks();
        int                    k;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        logic [7:0]            junk;
        wait_idle();
        for (k = 0; k < 2 * NTASK; k++) begin
            if (k < NTASK) begin
                // upper bits of a compute write are don't-care
                junk  = 8'($urandom_range(0, 255));
                idx   = REG_COMPUTE0 + CFG_IDX_W'(k);
                value = {junk, next_compute[k]};
            end else begin
                idx   = REG_PERIOD0 + CFG_IDX_W'(k - NTASK);
                value = next_period[k - NTASK];
            end
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= value;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (idx < REG_PERIOD0) begin
                task_compute[idx - REG_COMPUTE0] = value[7:0];
            end else begin
                task_period[idx - REG_PERIOD0] = value;
            end
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_backlog();
        int k;
        for (k = 0; k < NTASK; k++) begin
            next_compute[k] = 8'd0;
            next_period[k]  = task_period[k];
        end
        program_tasks();
        while (work_left()) send_tick(1'b0, 8'($urandom_range(0, 255)));
    endtask

    // reset defaults: arrival at tick zero, empty job, data without arrive
    task automatic test_arrivals_at_reset();
        send_tick(1'b1, 8'd2);
        send_tick(1'b1, 8'd0);
        send_tick(1'b0, 8'hFF);
        send_tick(1'b1, 8'd1);
        send_tick(1'b0, 8'd0);
        send_tick(1'b1, 8'hFF);
    endtask

    // shortest period first, tie to lower index, misses, zero period, disabled task
    task automatic test_rate_priority();
        int k;
        next_compute = '{8'd1, 8'd2, 8'd1, 8'd0};
        next_period  = '{16'd4, 16'd4, 16'd2, 16'd0};
        program_tasks();
        for (k = 0; k < 8; k++) send_tick(k == 2, 8'd3);
        next_compute = '{8'd0, 8'd0, 8'd1, 8'd0};
        next_period  = '{16'd4, 16'd4, 16'd0, 16'hFFFF};
        program_tasks();
        for (k = 0; k < 4; k++) send_tick(k == 0, 8'd1);
    endtask

    // shrink a period below the running phase so it wraps on the next tick
    task automatic test_phase_rewrite();
        int k;
        next_compute = '{8'd1, 8'd0, 8'd0, 8'd0};
        next_period  = '{16'd100, 16'd1, 16'd1, 16'd1};
        program_tasks();
        for (k = 0; k < 6; k++) send_tick(1'b0, 8'd0);
        next_period[0] = 16'd3;
        program_tasks();
        for (k = 0; k < 5; k++) send_tick(1'b0, 8'd0);
    endtask

    // periodic work keeps the queue from draining until it overflows
    task automatic test_queue_full();
        int k;
        next_compute = '{8'd20, 8'd0, 8'd0, 8'd0};
        next_period  = '{16'd1, 16'd1, 16'd1, 16'd1};
        program_tasks();
        for (k = 0; k < QDEPTH + 2; k++) send_tick(1'b1, 8'($urandom_range(1, 3)));
        drain_backlog();
    endtask

    // pending units pin at the maximum
    task automatic test_saturation();
        int k;
        next_compute = '{8'hFF, 8'd0, 8'd0, 8'd0};
        next_period  = '{16'd1, 16'd7, 16'd0, 16'hFFFF};
        program_tasks();
        for (k = 0; k < 270; k++) send_tick(k < QDEPTH + 4, 8'($urandom_range(1, 255)));
    endtask

    task automatic test_random_traffic(input int n_items);
        int         sent;
        int         k;
        int         j;
        int         seg;
        int         roll;
        int         per;
        logic [7:0] units;
        sent = 0;
        while (sent < n_items) begin
            for (k = 0; k < NTASK; k++) begin
                roll = $urandom_range(0, 19);
                if (roll == 0) begin
                    next_compute[k] = 8'd0;
                    next_period[k]  = 16'($urandom_range(0, 65535));
                end else if (roll == 1) begin
                    next_compute[k] = 8'hFF;
                    next_period[k]  = 16'hFFFF;
                end else if (roll == 2) begin
                    next_compute[k] = 8'd1;
                    next_period[k]  = 16'd0;
                end else begin
                    per = $urandom_range(1, 32);
                    next_period[k]  = 16'(per);
                    next_compute[k] = 8'($urandom_range(0, (per + 7) / 8));
                end
            end
            program_tasks();
            seg = $urandom_range(30, 80);
            for (j = 0; j < seg && sent < n_items; j++) begin
                roll = $urandom_range(0, 99);
                units = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 4))
                                                   : 8'($urandom_range(1, 255));
                if (roll < 2) wait_idle();
                if (roll < 4) begin
                    for (k = 0; k < QDEPTH + 2; k++) send_tick(1'b1, 8'($urandom_range(1, 3)));
                    sent += QDEPTH + 2;
                end else begin
                    if (roll < 28) begin
                        send_tick(1'b1, units);
                    end else if (roll < 33) begin
                        send_tick(1'b1, 8'd0);
                    end else begin
                        send_tick(1'b0, 8'($urandom_range(0, 255)));
                    end
                    sent++;
                end
            end
        end
    endtask

    initial begin : main
        int k;
        for (k = 0; k < NTASK; k++) begin
            task_compute[k] = 8'd0;
            task_period[k]  = 16'd1;
            task_phase[k]   = 16'd0;
            task_pending[k] = 16'd0;
        end
        for (k = 0; k < QDEPTH; k++) begin
            job_arrival[k] = 16'd0;
            job_left[k]    = 8'd0;
        end
        job_head  = 0;
        job_tail  = 0;
        job_count = 0;
        tick_ctr  = 16'd0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_arrivals_at_reset();
        test_rate_priority();
        test_phase_rewrite();
        test_queue_full();
        test_random_traffic(180);

        src_idle_pct  = 46;
        sink_idle_pct = 25;
        test_random_traffic(180);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(180);
        test_saturation();

        wait_idle();
        repeat (3) @(posedge i_clk);
        if (mismatch_count == 0 && expected_ticks.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
